/* rtl/tgarle_pkg.sv */
// Package for the TGA run-length pixel decoder: result type, register map,
// packet header constants and reset values. No dependencies.
`default_nettype none

package tgarle_pkg;

  // Header byte split: below RAW_LIMIT opens a raw packet, else a run
  localparam logic [7:0] RAW_LIMIT = 8'd128;
  localparam logic [7:0] RUN_BIAS  = 8'd127;

  // Input commands
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Configuration register map (word index)
  localparam logic REG_BPP   = 1'b0;
  localparam logic REG_TOTAL = 1'b1;

  localparam logic [2:0]  BPP_RESET   = 3'd4;
  localparam logic [23:0] TOTAL_RESET = 24'd1;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        status;
    logic        image_done;
  } result_t;

endpackage

`default_nettype wire

/* rtl/tgarle_in_if.sv */
// Input channel of the TGA run-length decoder: valid/ready plus one stream item.
// No dependencies.
`default_nettype none

interface tgarle_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] stream_byte;

  modport source (output valid, output cmd, output stream_byte, input ready);
  modport sink   (input valid, input cmd, input stream_byte, output ready);
endinterface

`default_nettype wire

/* rtl/tgarle_out_if.sv */
// Result channel of the TGA run-length decoder: valid/ready plus one decoded pixel.
// No dependencies.
`default_nettype none

interface tgarle_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [7:0]  repeat_count;
  logic        status;
  logic        image_done;

  modport source (output valid, output pixel_value, output repeat_count,
                  output status, output image_done, input ready);
  modport sink   (input valid, input pixel_value, input repeat_count,
                  input status, input image_done, output ready);
endinterface

`default_nettype wire

/* rtl/tgarle_core.sv */
// Decode state of the TGA run-length decoder: packet tracking, pixel byte
// gathering and pixel count checking. Depends on tgarle_pkg.
`default_nettype none

module tgarle_core #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic             cmd,
  input  wire logic [7:0]       stream_byte,
  input  wire logic [2:0]       bpp,
  input  wire logic [23:0]      pixel_total,
  output logic                  res_push,
  output tgarle_pkg::result_t   res
);
  import tgarle_pkg::*;

  typedef enum logic [1:0] {
    MODE_HEADER = 2'd0,
    MODE_RAW    = 2'd1,
    MODE_RUN    = 2'd2
  } mode_t;

  mode_t                 mode_r, mode_nxt;
  logic [7:0]            left_r, left_nxt;
  logic [1:0]            slot_r, slot_nxt;
  logic [31:0]           gather_r, gather_nxt;
  logic [COUNT_BITS-1:0] done_r, done_nxt;
  logic                  halted_r, halted_nxt;

  logic [1:0]            last_slot;
  logic [31:0]           gather_cat;
  logic [7:0]            left_dec;
  logic [7:0]            count;
  logic [7:0]            clip;
  logic                  ends;
  logic [COUNT_BITS-1:0] total;
  logic [COUNT_BITS-1:0] remain;
  logic [COUNT_BITS-1:0] done_sum;
  logic                  err;
  logic                  fin;

  // Out-of-range pixel widths clamp to 1 or 4 bytes
  always_comb begin
    case (bpp) inside
      3'd0, 3'd1: last_slot = 2'd0;
      3'd2:       last_slot = 2'd1;
      3'd3:       last_slot = 2'd2;
      default:    last_slot = 2'd3;
    endcase
  end

  always_comb begin
    gather_cat = gather_r | ({24'd0, stream_byte} << {slot_r, 3'b000});
    left_dec   = left_r - 8'd1;
    if (mode_r == MODE_RAW) begin
      count = 8'd1;
      ends  = (left_dec == 8'd0);
    end else begin
      count = left_r;
      ends  = 1'b1;
    end
    total    = COUNT_BITS'(pixel_total);
    remain   = (total > done_r) ? (total - done_r) : '0;
    err      = (COUNT_BITS'(count) > remain);
    // remain is below count here, so it fits the count width
    clip     = err ? remain[7:0] : count;
    done_sum = done_r + COUNT_BITS'(clip);
    fin      = !err && ends && (done_sum >= total);
  end

  always_comb begin
    mode_nxt   = mode_r;
    left_nxt   = left_r;
    slot_nxt   = slot_r;
    gather_nxt = gather_r;
    done_nxt   = done_r;
    halted_nxt = halted_r;
    res_push   = 1'b0;

    res.pixel_value  = gather_cat;
    res.repeat_count = clip;
    res.status       = err;
    res.image_done   = fin;

    if (accept) begin
      if (cmd == CMD_START) begin
        mode_nxt   = MODE_HEADER;
        left_nxt   = '0;
        slot_nxt   = '0;
        gather_nxt = '0;
        done_nxt   = '0;
        halted_nxt = 1'b0;
      end else if (!halted_r) begin
        if (mode_r != MODE_RAW && mode_r != MODE_RUN) begin
          if (stream_byte < RAW_LIMIT) begin
            mode_nxt = MODE_RAW;
            left_nxt = stream_byte + 8'd1;
          end else begin
            mode_nxt = MODE_RUN;
            left_nxt = stream_byte - RUN_BIAS;
          end
          slot_nxt   = '0;
          gather_nxt = '0;
        end else if (slot_r < last_slot) begin
          slot_nxt   = slot_r + 2'd1;
          gather_nxt = gather_cat;
        end else begin
          res_push   = 1'b1;
          slot_nxt   = '0;
          gather_nxt = '0;
          left_nxt   = (mode_r == MODE_RAW) ? left_dec : 8'd0;
          if (ends) begin
            mode_nxt = MODE_HEADER;
          end
          done_nxt = done_sum;
          if (err || fin) begin
            halted_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_HEADER;
      left_r   <= '0;
      slot_r   <= '0;
      gather_r <= '0;
      done_r   <= '0;
      halted_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      left_r   <= left_nxt;
      slot_r   <= slot_nxt;
      gather_r <= gather_nxt;
      done_r   <= done_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/tgarle_outq.sv */
// Two-entry result queue of the TGA run-length decoder: output register plus
// skid slot. Depends on tgarle_pkg.
`default_nettype none

module tgarle_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire tgarle_pkg::result_t  push_data,
  input  wire logic                 pop,
  output logic                      full,
  output logic                      valid,
  output tgarle_pkg::result_t       head
);
  import tgarle_pkg::*;

  result_t    slot0_r, slot0_nxt;
  result_t    slot1_r, slot1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] wr_idx;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    // advance the skid entry into the head on a pop
    if (pop && cnt_r == 2'd2) begin
      slot0_nxt = slot1_r;
    end
    wr_idx = cnt_r - {1'b0, pop};
    if (push) begin
      if (wr_idx == 2'd0) begin
        slot0_nxt = push_data;
      end else begin
        slot1_nxt = push_data;
      end
    end
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign valid = (cnt_r != 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = slot0_r;

endmodule

`default_nettype wire

/* rtl/tga_rle_pixel_decoder_top.sv */
// TGA run-length pixel decoder, top level. Takes one stream item per cycle while in ready is high.
// A result is pushed into the result queue as its last pixel byte is taken, and leaves from its head.
// Throughput: one item per cycle; the two-entry result queue lets input run while
//   a result waits, and in ready drops only when both entries hold results.
// Reset: synchronous, active low; clears decode state, sets bytes per pixel to 4
//   and the pixel total to 1. Depends on tgarle_pkg, interfaces, core and queue.
`default_nettype none

module tga_rle_pixel_decoder_top #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  tgarle_in_if.sink          in_ch,
  tgarle_out_if.source       out_ch,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [2:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import tgarle_pkg::*;

  logic [2:0]  bpp_r;
  logic [23:0] total_r;
  logic        cfg_wr;
  logic        accept;
  logic        res_push;
  result_t     res;
  logic        q_full;
  logic        q_valid;
  result_t     q_head;
  logic        pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r   <= BPP_RESET;
      total_r <= TOTAL_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_BPP:   bpp_r   <= cfg_pwdata[2:0];
        REG_TOTAL: total_r <= cfg_pwdata[23:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_BPP:   cfg_prdata = {29'd0, bpp_r};
      REG_TOTAL: cfg_prdata = {8'd0, total_r};
      default:   cfg_prdata = '0;
    endcase
  end

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  tgarle_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cmd         (in_ch.cmd),
    .stream_byte (in_ch.stream_byte),
    .bpp         (bpp_r),
    .pixel_total (total_r),
    .res_push    (res_push),
    .res         (res)
  );

  tgarle_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  assign out_ch.valid        = q_valid;
  assign out_ch.pixel_value  = q_head.pixel_value;
  assign out_ch.repeat_count = q_head.repeat_count;
  assign out_ch.status       = q_head.status;
  assign out_ch.image_done   = q_head.image_done;

endmodule

`default_nettype wire

/* rtl/tgarle_checker.sv */
// Port-level checks for the TGA run-length decoder and the bind that attaches
// them to the top level. Depends on tga_rle_pixel_decoder_top.
`default_nettype none

module tgarle_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_pixel_value,
  input wire logic [7:0]  out_repeat_count,
  input wire logic        out_status,
  input wire logic        out_image_done
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_value) &&
      $stable(out_repeat_count) && $stable(out_status) && $stable(out_image_done))
    else $error("stalled result changed");

  // input backs up only behind a waiting result
  a_ready_vs_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result queue not empty after reset");

  // a completed image always carries at least one pixel and no error
  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_done |-> !out_status && (out_repeat_count != 8'd0))
    else $error("image done with error or empty count");

endmodule

bind tga_rle_pixel_decoder_top tgarle_checker u_tgarle_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_pixel_value  (out_ch.pixel_value),
  .out_repeat_count (out_ch.repeat_count),
  .out_status       (out_ch.status),
  .out_image_done   (out_ch.image_done)
);

`default_nettype wire

/* verif/tga_rle_pixel_decoder_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for tga_rle_pixel_decoder_top: drives coded images over the
// input channel and APB writes, predicts every decoded pixel result and checks it.
// Depends on tgarle_pkg, tgarle_in_if, tgarle_out_if and the decoder RTL.

typedef enum logic [1:0] {PKT_HEADER, PKT_RAW, PKT_RUN} pkt_mode_t;

class tga_pixel_scoreboard;
  logic [2:0]  bpp_reg;
  logic [23:0] total_reg;

  pkt_mode_t   mode;
  logic [7:0]  pkt_left;
  logic [1:0]  slot;
  logic [31:0] gather;
  logic [23:0] pixels_done;
  bit          halted;

  tgarle_pkg::result_t pixel_q[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned images_done;
  int unsigned overruns;

  function new();
    bpp_reg   = tgarle_pkg::BPP_RESET;
    total_reg = tgarle_pkg::TOTAL_RESET;
    clear_image();
  endfunction

  function void clear_image();
    mode        = PKT_HEADER;
    pkt_left    = '0;
    slot        = '0;
    gather      = '0;
    pixels_done = '0;
    halted      = 1'b0;
  endfunction

  function void write_reg(logic idx, logic [31:0] value);
    if (idx == tgarle_pkg::REG_BPP) bpp_reg = value[2:0];
    else total_reg = value[23:0];
  endfunction

  function int unsigned pending();
    return pixel_q.size();
  endfunction

  // Returns 0 when the item is dropped by a halted decoder.
  function bit note_input(logic cmd, logic [7:0] b);
    int unsigned eff;
    logic [7:0]  count;
    logic [23:0] remain;
    bit          ends;
    bit          err;
    bit          done_flag;
    tgarle_pkg::result_t r;
    if (cmd == tgarle_pkg::CMD_START) begin
      clear_image();
      return 1'b1;
    end
    if (halted) return 1'b0;
    if (mode == PKT_HEADER) begin
      if (b < tgarle_pkg::RAW_LIMIT) begin
        mode     = PKT_RAW;
        pkt_left = b + 8'd1;
      end else begin
        mode     = PKT_RUN;
        pkt_left = b - tgarle_pkg::RUN_BIAS;
      end
      slot   = '0;
      gather = '0;
      return 1'b1;
    end
    eff = (bpp_reg == 3'd0) ? 1 : (bpp_reg > 3'd4) ? 4 : int'(bpp_reg);
    gather = gather | (32'(b) << (int'(slot) * 8));
    if (int'(slot) + 1 < eff) begin
      slot = slot + 2'd1;
      return 1'b1;
    end
    r.pixel_value = gather;
    slot   = '0;
    gather = '0;
    if (mode == PKT_RAW) begin
      count    = 8'd1;
      pkt_left = pkt_left - 8'd1;
      ends     = (pkt_left == 8'd0);
    end else begin
      count    = pkt_left;
      pkt_left = '0;
      ends     = 1'b1;
    end
    if (ends) mode = PKT_HEADER;
    remain    = (total_reg > pixels_done) ? total_reg - pixels_done : 24'd0;
    err       = (24'(count) > remain);
    done_flag = 1'b0;
    if (err) begin
      count  = remain[7:0];
      halted = 1'b1;
    end
    pixels_done = pixels_done + 24'(count);
    if (!err && ends && pixels_done >= total_reg) begin
      done_flag = 1'b1;
      halted    = 1'b1;
    end
    r.repeat_count = count;
    r.status       = err;
    r.image_done   = done_flag;
    pixel_q.push_back(r);
    return 1'b1;
  endfunction

  function void check_result(tgarle_pkg::result_t got);
    tgarle_pkg::result_t want;
    results_seen++;
    if (pixel_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result pixel=%h count=%0d status=%0b done=%0b",
                 got.pixel_value, got.repeat_count, got.status, got.image_done);
      return;
    end
    want = pixel_q.pop_front();
    if (want.image_done) images_done++;
    if (want.status) overruns++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result %0d expected pixel=%h count=%0d status=%0b done=%0b, got pixel=%h count=%0d status=%0b done=%0b",
                 results_seen, want.pixel_value, want.repeat_count, want.status,
                 want.image_done, got.pixel_value, got.repeat_count, got.status,
                 got.image_done);
    end
  endfunction
endclass

module tga_rle_pixel_decoder_top_tb;
  import tgarle_pkg::*;

  localparam int ITEM_GOAL     = 1750;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_LIMIT    = 4000;

  localparam int STYLE_EXACT = 0;
  localparam int STYLE_OVER  = 1;
  localparam int STYLE_OPEN  = 2;
  localparam int STYLE_NOISE = 3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  tgarle_in_if  in_ch ();
  tgarle_out_if out_ch ();

  tga_pixel_scoreboard pixel_sb = new();

  bit tx_steady;
  bit rx_steady;
  bit hold_req;
  int unsigned live_items;
  int unsigned idle_cycles;

  tga_rle_pixel_decoder_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  function automatic int tx_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int rx_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly short packets, now and then anything up to the cap.
  function automatic int pick_len(int cap);
    if (cap < 1) return 1;
    if ($urandom_range(0, 3) != 0) return $urandom_range(1, (cap < 8) ? cap : 8);
    return $urandom_range(1, cap);
  endfunction

  function automatic int eff_bpp();
    if (pixel_sb.bpp_reg == 3'd0) return 1;
    if (pixel_sb.bpp_reg > 3'd4) return 4;
    return int'(pixel_sb.bpp_reg);
  endfunction

  // Receiver: random back-pressure, steady stretches, and one long hold on request.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_steady || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (rx_gap()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      pixel_sb.check_result({out_ch.pixel_value, out_ch.repeat_count,
                             out_ch.status, out_ch.image_done});
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable && cfg_pwrite))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
      $display("tga_rle_pixel_decoder_top_tb NOT OK");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] b);
    int gap;
    gap = tx_steady ? 0 : tx_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.stream_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (pixel_sb.note_input(cmd, b)) live_items++;
  endtask

  // Drop valid and wait for every expected pixel, then let the pipeline empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pixel_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    pixel_sb.write_reg(idx, value);
    // leave the bus idle before the next transfer
    @(posedge clk);
  endtask

  task automatic send_pixel();
    repeat (eff_bpp()) send_item(CMD_DATA, rand_byte());
  endtask

  task automatic send_packet(input int len, input bit raw);
    send_item(CMD_DATA, raw ? 8'(len - 1) : 8'(len + 127));
    repeat (raw ? len : 1) send_pixel();
  endtask

  task automatic run_image(input int style);
    int left;
    int len;
    bit last;
    send_item(CMD_START, rand_byte());
    left = int'(pixel_sb.total_reg);
    last = 1'b0;
    case (style)
      STYLE_EXACT: begin
        while (left > 0) begin
          len = pick_len((left < 128) ? left : 128);
          send_packet(len, 1'($urandom_range(0, 1)));
          left -= len;
        end
      end
      STYLE_OVER: begin
        while (!last) begin
          if (left < 128 && (left <= 4 || $urandom_range(0, 2) == 0)) begin
            len  = left + $urandom_range(1, (128 - left < 8) ? 128 - left : 8);
            last = 1'b1;
          end else begin
            len = pick_len((left - 1 < 128) ? left - 1 : 128);
          end
          send_packet(len, 1'($urandom_range(0, 1)));
          left -= len;
        end
      end
      STYLE_OPEN: begin
        repeat ($urandom_range(5, 20)) send_packet(pick_len(128), 1'($urandom_range(0, 1)));
      end
      default: begin
        // broken streams: random bytes with the odd restart
        repeat ($urandom_range(10, 40))
          send_item(($urandom_range(0, 15) == 0) ? CMD_START : CMD_DATA, rand_byte());
      end
    endcase
    // trailing bytes after the image; after an exact or overrun image they land on a halted decoder
    repeat ($urandom_range(0, 3)) send_item(CMD_DATA, rand_byte());
  endtask

  task automatic directed_checks();
    cfg_write(REG_BPP, 32'd4);
    cfg_write(REG_TOTAL, 32'd3);
    send_item(CMD_START, 8'h00);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'h80);
    send_item(CMD_DATA, 8'h7F);
    // run of 128 against two pixels left: clipped, flagged, halted
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'h12);
    send_item(CMD_DATA, 8'h34);
    send_item(CMD_DATA, 8'h56);
    send_item(CMD_DATA, 8'h78);
    send_item(CMD_DATA, 8'h55);
    settle();
    cfg_write(REG_BPP, 32'd1);
    cfg_write(REG_TOTAL, 32'd2);
    send_item(CMD_START, 8'hFF);
    send_item(CMD_DATA, 8'h81);
    send_item(CMD_DATA, 8'hAA);
    send_item(CMD_DATA, 8'h01);
    // raw packet crossing the total mid-packet
    send_item(CMD_START, 8'h00);
    send_item(CMD_DATA, 8'h02);
    send_item(CMD_DATA, 8'h11);
    send_item(CMD_DATA, 8'h22);
    send_item(CMD_DATA, 8'h33);
    settle();
  endtask

  initial begin
    logic [2:0]  bpp_sel [8];
    logic [23:0] total_sel;
    int          phase;
    int          roll;
    bpp_sel = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd5, 3'd6, 3'd7};
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_DATA;
    in_ch.stream_byte <= 8'h00;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req  = 1'b0;
    live_items  = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_checks();

    phase = 0;
    while (live_items < ITEM_GOAL || phase < 8) begin
      case (phase % 6)
        0:       total_sel = 24'd1;
        1:       total_sel = 24'($urandom_range(2, 40));
        2:       total_sel = 24'd0;
        3:       total_sel = 24'($urandom_range(40, 120));
        4:       total_sel = 24'hFFFFFF;
        default: total_sel = 24'($urandom_range(1, 12));
      endcase
      settle();
      if ($urandom_range(0, 1)) begin
        cfg_write(REG_BPP, 32'(bpp_sel[phase % 8]));
        cfg_write(REG_TOTAL, 32'(total_sel));
      end else begin
        cfg_write(REG_TOTAL, 32'(total_sel));
        cfg_write(REG_BPP, 32'(bpp_sel[phase % 8]));
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      // fill the result queue so the input stalls
      if (phase == 3) begin
        tx_steady = 1'b1;
        hold_req  = 1'b1;
      end
      repeat (2) begin
        if (pixel_sb.total_reg == 24'hFFFFFF) begin
          run_image(STYLE_OPEN);
          // lower the total under what is already decoded, then keep going
          settle();
          cfg_write(REG_TOTAL, 32'($urandom_range(0, int'(pixel_sb.pixels_done) - 1)));
          repeat (2) send_packet(pick_len(16), 1'($urandom_range(0, 1)));
          settle();
          cfg_write(REG_TOTAL, 32'(total_sel));
        end else if (pixel_sb.total_reg == 24'd0) begin
          run_image(STYLE_OVER);
        end else begin
          roll = $urandom_range(0, 19);
          run_image((roll < 12) ? STYLE_EXACT : (roll < 17) ? STYLE_OVER : STYLE_NOISE);
        end
      end
      phase++;
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Decoded %0d live items into %0d results over %0d register settings;",
             live_items, pixel_sb.results_seen, phase + 2);
    $display("%0d images completed, %0d overruns clipped, %0d mismatches.",
             pixel_sb.images_done, pixel_sb.overruns, pixel_sb.mismatches);
    if (pixel_sb.mismatches == 0 && pixel_sb.pending() == 0)
      $display("tga_rle_pixel_decoder_top_tb OK");
    else
      $display("tga_rle_pixel_decoder_top_tb NOT OK");
    $finish;
  end
endmodule

/* filelist.f */
rtl/tgarle_pkg.sv
rtl/tgarle_in_if.sv
rtl/tgarle_out_if.sv
rtl/tgarle_core.sv
rtl/tgarle_outq.sv
rtl/tga_rle_pixel_decoder_top.sv
rtl/tgarle_checker.sv
verif/tga_rle_pixel_decoder_top_tb.sv
